/* rtl/i2crs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_pkg
// Shared types and constants for the I2C register target.
// ----------------------------------------------------------------------------
package i2crs_pkg;

  typedef enum logic [1:0] {
    MODE_WR_START = 2'd0,
    MODE_RD_START = 2'd1,
    MODE_WR_BYTE  = 2'd2,
    MODE_RD_BYTE  = 2'd3
  } mode_t;

  localparam logic [15:0] ID_ADDRESS = 16'h3B00;
  localparam logic [7:0]  ID_VALUE   = 8'h28;
  localparam logic [7:0]  EMPTY_BYTE = 8'hFF;

  // Store access from the control logic; wr and rd never both set.
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } store_req_t;

endpackage

/* rtl/i2crs_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_regfile
// Windowed byte store with reset sweep; maps bus addresses to store offsets.
// ----------------------------------------------------------------------------
module i2crs_regfile
  import i2crs_pkg::*;
#(
  parameter int WINDOW_SIZE = 4096,
  parameter int WINDOW_BASE = 12288
) (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output logic       busy,
  output logic [7:0] rdata
);

  localparam int OFS_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam bit ID_IN = (int'(ID_ADDRESS) >= WINDOW_BASE) &&
                         (int'(ID_ADDRESS) - WINDOW_BASE < WINDOW_SIZE);
  localparam logic [OFS_W-1:0] ID_OFS =
    ID_IN ? OFS_W'(int'(ID_ADDRESS) - WINDOW_BASE) : '0;
  localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(WINDOW_SIZE - 1);

  logic [7:0]       mem [WINDOW_SIZE];
  logic [7:0]       mem_q;
  logic             hit_q;
  logic             clearing;
  logic [OFS_W-1:0] clr_idx;

  logic [16:0]      diff;
  logic             hit;
  logic [OFS_W-1:0] ofs;
  logic             mem_we;
  logic [OFS_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  always_comb begin
    diff = {1'b0, req.addr} - 17'(WINDOW_BASE);
    hit  = (req.addr >= 16'(WINDOW_BASE)) && (diff < 17'(WINDOW_SIZE));
    ofs  = diff[OFS_W-1:0];
    mem_we    = clearing || (req.wr && hit);
    mem_waddr = clearing ? clr_idx : ofs;
    if (clearing) begin
      mem_wdata = (ID_IN && (clr_idx == ID_OFS)) ? ID_VALUE : EMPTY_BYTE;
    end else begin
      mem_wdata = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST_OFS) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req.rd) begin
      mem_q <= mem[ofs];
      hit_q <= hit;
    end
  end

  assign busy  = clearing;
  assign rdata = hit_q ? mem_q : EMPTY_BYTE;

  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(req.wr || req.rd))
    else $error("store request during reset sweep");

  a_sweep_once: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("reset sweep restarted");

  a_wr_rd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(req.wr && req.rd))
    else $error("simultaneous store write and read");

endmodule

/* rtl/i2c_register_slave_16bit_addr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_slave_16bit_addr
// Transaction-level I2C target with a byte register window at a 16-bit
// address.
//
//   channel  dir  fields (tuser | tdata)            result
//   s_*      in   mode[1:0] | write_data[7:0]       one per read byte request
//   m_*      out  - | read_data[7:0]                -
//
// One transaction accepted per cycle while s_tready is high; a read byte
// appears on m_* after its request is accepted, through the store read
// register, then the output register. After reset a sweep writes every
// store entry, with s_tready low throughout.
// A stalled result holds s_tready low only while a second read is also
// waiting behind it.
// ----------------------------------------------------------------------------
module i2c_register_slave_16bit_addr
  import i2crs_pkg::*;
#(
  parameter int WINDOW_SIZE = 4096,
  parameter int WINDOW_BASE = 12288
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // write_data[7:0]
  input  logic [1:0] s_tuser,   // mode[1:0]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // read_data[7:0]
);

  logic [7:0]  addr_high, addr_high_next;
  logic [7:0]  addr_low, addr_low_next;
  logic [1:0]  addr_seen, addr_seen_next;
  logic [15:0] read_pointer, read_pointer_next;
  logic        rd_pend;
  logic [7:0]  out_data;

  store_req_t  req;
  logic        busy;
  logic [7:0]  store_rdata;
  logic        accept;
  logic        pend_move;
  mode_t       mode;

  assign mode      = mode_t'(s_tuser);
  assign pend_move = rd_pend && (!m_tvalid || m_tready);
  assign s_tready  = !busy && !(rd_pend && m_tvalid && !m_tready);
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    addr_high_next    = addr_high;
    addr_low_next     = addr_low;
    addr_seen_next    = addr_seen;
    read_pointer_next = read_pointer;
    req.wr    = 1'b0;
    req.rd    = 1'b0;
    req.addr  = {addr_high, addr_low};
    req.wdata = s_tdata;
    if (accept) begin
      unique case (mode)
        MODE_WR_START: begin
          addr_seen_next = 2'd0;
        end
        MODE_RD_START: begin
          read_pointer_next = {addr_high, addr_low};
        end
        MODE_WR_BYTE: begin
          priority if (addr_seen == 2'd0) begin
            addr_high_next = s_tdata;
            addr_seen_next = 2'd1;
          end else if (addr_seen == 2'd1) begin
            addr_low_next  = s_tdata;
            addr_seen_next = 2'd2;
          end else begin
            req.wr = 1'b1;
            {addr_high_next, addr_low_next} = {addr_high, addr_low} + 16'd1;
          end
        end
        MODE_RD_BYTE: begin
          req.rd            = 1'b1;
          req.addr          = read_pointer;
          read_pointer_next = read_pointer + 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_high    <= '0;
      addr_low     <= '0;
      addr_seen    <= '0;
      read_pointer <= '0;
      rd_pend      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      addr_high    <= addr_high_next;
      addr_low     <= addr_low_next;
      addr_seen    <= addr_seen_next;
      read_pointer <= read_pointer_next;
      if (req.rd) begin
        rd_pend <= 1'b1;
      end else if (pend_move) begin
        rd_pend <= 1'b0;
      end
      if (pend_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data <= store_rdata;
    end
  end

  assign m_tdata = out_data;

  i2crs_regfile #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .WINDOW_BASE (WINDOW_BASE)
  ) u_regfile (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .busy  (busy),
    .rdata (store_rdata)
  );

  a_seen_saturates: assert property (@(posedge clk) disable iff (rst)
    addr_seen != 2'd3)
    else $error("address byte count out of range");

  a_pend_kept: assert property (@(posedge clk) disable iff (rst)
    rd_pend && !pend_move |=> rd_pend)
    else $error("pending read dropped");

  a_rd_advances: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_RD_BYTE) |=> read_pointer == $past(read_pointer) + 16'd1)
    else $error("read pointer did not advance");

  a_pend_reaches_out: assert property (@(posedge clk) disable iff (rst)
    pend_move |=> m_tvalid)
    else $error("read result lost");

endmodule

/* bench/i2c_register_slave_16bit_addr_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_slave_16bit_addr_tb
// Self-checking bench for the 16-bit address I2C register target. Bus events
// come from a queue. Each accepted event updates a local copy of the address
// registers, the read pointer and the register window. Every read byte request
// queues the byte it should return, and each result on m_* is checked against
// the oldest queued byte. A directed opening covers the identification entry,
// the top window edge, address-byte handling and 16-bit wrap. Random well-formed
// write and read sequences follow, with noise mixed in. Both sides idle and
// stall in rotating phases.
// ----------------------------------------------------------------------------
module i2c_register_slave_16bit_addr_tb
  import i2crs_pkg::*;
();

  localparam int WINDOW_SIZE = 4096;
  localparam int WINDOW_BASE = 12288;
  localparam int RANDOM_EVENTS = 550;

  typedef struct {
    mode_t      mode;
    logic [7:0] data;
    bit         drain;
  } bus_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // write_data[7:0]
  logic [1:0] s_tuser = 2'b00;   // mode[1:0]
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // read_data[7:0]

  bus_event_t pending_events[$];
  logic [7:0] expected_bytes[$];
  bus_event_t next_event;
  bit         drain_next;
  bit         s_taken = 1'b0;
  bit         sender_idle;
  int         n_accepted = 0;
  int         error_count = 0;

  // local copy of the target state
  logic [7:0]  addr_hi;
  logic [7:0]  addr_lo;
  logic [1:0]  addr_bytes;
  logic [15:0] rd_ptr;
  logic [7:0]  window_mem [WINDOW_SIZE];

  i2c_register_slave_16bit_addr #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .WINDOW_BASE(WINDOW_BASE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic bit in_window(input logic [15:0] a);
    int ia;
    ia = a;
    return (ia >= WINDOW_BASE) && (ia - WINDOW_BASE < WINDOW_SIZE);
  endfunction

  task automatic predict_register_access(input mode_t mode, input logic [7:0] data);
    logic [15:0] addr;
    case (mode)
      MODE_WR_START: addr_bytes = 2'd0;
      MODE_RD_START: rd_ptr = {addr_hi, addr_lo};
      MODE_WR_BYTE: begin
        if (addr_bytes == 2'd0) begin
          addr_hi = data;
          addr_bytes = 2'd1;
        end else if (addr_bytes == 2'd1) begin
          addr_lo = data;
          addr_bytes = 2'd2;
        end else begin
          addr = {addr_hi, addr_lo};
          if (in_window(addr)) window_mem[int'(addr) - WINDOW_BASE] = data;
          addr = addr + 16'd1;
          {addr_hi, addr_lo} = addr;
        end
      end
      default: begin
        if (in_window(rd_ptr)) expected_bytes.push_back(window_mem[int'(rd_ptr) - WINDOW_BASE]);
        else expected_bytes.push_back(EMPTY_BYTE);
        rd_ptr = rd_ptr + 16'd1;
      end
    endcase
  endtask

  task automatic queue_event(input mode_t mode, input logic [7:0] data);
    pending_events.push_back('{mode: mode, data: data, drain: drain_next});
    drain_next = 1'b0;
  endtask

  task automatic queue_address(input logic [15:0] a);
    queue_event(MODE_WR_START, 8'h00);
    queue_event(MODE_WR_BYTE, a[15:8]);
    queue_event(MODE_WR_BYTE, a[7:0]);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 6))
      0, 1: return 16'(WINDOW_BASE + $urandom_range(0, 31));
      2: return 16'(int'(ID_ADDRESS) - 4 + $urandom_range(0, 7));
      3: return 16'(WINDOW_BASE + WINDOW_SIZE - 8 + $urandom_range(0, 15));
      4: return 16'(WINDOW_BASE - 8 + $urandom_range(0, 15));
      5: return 16'(16'hFFF8 + $urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int idle_phase();
    return (n_accepted / 64) % 4;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !((idle_phase() == 2 && $urandom_range(0, 99) < 63) ||
                    (idle_phase() == 3 && $urandom_range(0, 99) < 10));
      if (!s_tvalid || s_taken) begin
        sender_idle = (idle_phase() == 1 && $urandom_range(0, 99) < 63) ||
                      (idle_phase() == 3 && $urandom_range(0, 99) < 10);
        if (pending_events.size() != 0 && !sender_idle &&
            !(pending_events[0].drain && expected_bytes.size() != 0)) begin
          next_event = pending_events.pop_front();
          s_tuser  <= next_event.mode;
          s_tdata  <= next_event.data;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // accepted transactions feed the prediction
  always @(posedge clk) begin
    s_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_register_access(mode_t'(s_tuser), s_tdata);
      n_accepted <= n_accepted + 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("read_data: unexpected result, expected none, actual %02h", m_tdata);
        error_count++;
      end else if (m_tdata !== expected_bytes[0]) begin
        $error("read_data mismatch: expected %02h, actual %02h", expected_bytes[0], m_tdata);
        error_count++;
        void'(expected_bytes.pop_front());
      end else begin
        void'(expected_bytes.pop_front());
      end
    end
  end

  initial begin
    int n;
    logic [15:0] a;

    addr_hi = 8'h00;
    addr_lo = 8'h00;
    addr_bytes = 2'd0;
    rd_ptr = 16'h0000;
    for (int i = 0; i < WINDOW_SIZE; i++) window_mem[i] = EMPTY_BYTE;
    if (in_window(ID_ADDRESS)) window_mem[int'(ID_ADDRESS) - WINDOW_BASE] = ID_VALUE;
    drain_next = 1'b0;

    // read before any address was written
    queue_event(MODE_RD_START, 8'h00);
    queue_event(MODE_RD_BYTE, 8'h00);
    // identification entry
    queue_address(ID_ADDRESS);
    queue_event(MODE_RD_START, 8'h00);
    queue_event(MODE_RD_BYTE, 8'h00);
    // top of window, second byte falls outside
    queue_address(16'h3FFF);
    queue_event(MODE_WR_BYTE, 8'h00);
    queue_event(MODE_WR_BYTE, 8'hFF);
    // address bytes only, then read back across the top edge
    queue_address(16'h3FFF);
    queue_event(MODE_RD_START, 8'h00);
    queue_event(MODE_RD_BYTE, 8'h00);
    queue_event(MODE_RD_BYTE, 8'h00);
    // read pointer and write address wrap at 0xFFFF
    queue_address(16'hFFFF);
    queue_event(MODE_RD_START, 8'h00);
    queue_event(MODE_RD_BYTE, 8'h00);
    queue_event(MODE_RD_BYTE, 8'h00);
    queue_event(MODE_WR_BYTE, 8'h5A);

    n = pending_events.size() + RANDOM_EVENTS;
    drain_next = 1'b1;
    while (pending_events.size() < n) begin
      if (pending_events.size() > n / 2 && pending_events.size() < n / 2 + 8) drain_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          queue_address(pick_address());
          repeat ($urandom_range(0, 6)) queue_event(MODE_WR_BYTE, 8'($urandom));
        end
        4, 5, 6: begin
          queue_address(pick_address());
          queue_event(MODE_RD_START, 8'($urandom));
          repeat ($urandom_range(1, 6)) queue_event(MODE_RD_BYTE, 8'($urandom));
        end
        7: begin
          queue_event(MODE_RD_START, 8'($urandom));
          repeat ($urandom_range(1, 4)) queue_event(MODE_RD_BYTE, 8'($urandom));
        end
        8: begin
          a = pick_address();
          queue_event(MODE_WR_START, 8'($urandom));
          queue_event(MODE_WR_BYTE, a[15:8]);
          queue_event(MODE_RD_START, 8'($urandom));
          queue_event(MODE_RD_BYTE, 8'($urandom));
          queue_event(MODE_WR_BYTE, 8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 3)) queue_event(mode_t'($urandom_range(0, 3)), 8'($urandom));
        end
      endcase
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_events.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (error_count == 0) begin
      $display("i2c_register_slave_16bit_addr_tb: clean");
    end else begin
      $display("i2c_register_slave_16bit_addr_tb: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("i2c_register_slave_16bit_addr_tb: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/i2crs_pkg.sv
rtl/i2crs_regfile.sv
rtl/i2c_register_slave_16bit_addr.sv
bench/i2c_register_slave_16bit_addr_tb.sv
